[rtl/bmorph_pkg.sv]
// ---------------------------------------------------------------------------
// bmorph_pkg
// Shared types, constants and helpers for the 3x3 binary morphology unit.
// ---------------------------------------------------------------------------
package bmorph_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 13;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int POS_W       = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DIV_CNT_W   = $clog2(POS_W + 1);
  localparam int CFG_DATA_W  = 13;
  localparam int FIFO_DEPTH  = 3;
  localparam int FIFO_PTR_W  = 2;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_OPERATION     = 2'd2,
    REG_ELEMENT_SHAPE = 2'd3
  } cfg_reg_t;

  localparam logic OP_ERODE  = 1'b0;
  localparam logic OP_DILATE = 1'b1;

  localparam logic [2:0] SHAPE_CROSS   = 3'd0;
  localparam logic [2:0] SHAPE_HORIZ   = 3'd1;
  localparam logic [2:0] SHAPE_VERT    = 3'd2;
  localparam logic [2:0] SHAPE_PLUS45  = 3'd3;
  localparam logic [2:0] SHAPE_MINUS45 = 3'd4;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(512);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(512);

  typedef struct packed {
    logic result_on;
    logic frame_last;
  } result_t;

  // window bit k = row*3 + col, row 0 oldest line, col 2 newest column
  function automatic logic [8:0] shape_mask(input logic [2:0] shape);
    logic [8:0] m;
    case (shape)
      SHAPE_CROSS:   m = 9'h0AA;
      SHAPE_HORIZ:   m = 9'h028;
      SHAPE_VERT:    m = 9'h082;
      SHAPE_PLUS45:  m = 9'h044;
      SHAPE_MINUS45: m = 9'h101;
      default:       m = 9'h1EF;
    endcase
    return m;
  endfunction

endpackage

[rtl/bmorph_in_if.sv]
// ---------------------------------------------------------------------------
// bmorph_in_if
// Mask pixel channel: valid/ready handshake with kind and pixel bit.
// ---------------------------------------------------------------------------
interface bmorph_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic pixel_on;

  modport source (output valid, output kind, output pixel_on, input ready);
  modport sink   (input valid, input kind, input pixel_on, output ready);
endinterface

[rtl/bmorph_out_if.sv]
// ---------------------------------------------------------------------------
// bmorph_out_if
// Result pixel channel: valid/ready handshake with result and end of frame.
// ---------------------------------------------------------------------------
interface bmorph_out_if;
  logic valid;
  logic ready;
  logic result_on;
  logic frame_last;

  modport source (output valid, output result_on, output frame_last, input ready);
  modport sink   (input valid, input result_on, input frame_last, output ready);
endinterface

[rtl/binary_morphology_3x3_unit.sv]
// ---------------------------------------------------------------------------
// binary_morphology_3x3_unit
// 3x3 binary erosion / dilation on a raster-order mask stream.
// ---------------------------------------------------------------------------
// Takes one mask pixel per clock while in_ch.ready is high and returns one
// result pixel per clock, once the window is primed, while out_ch.ready is
// high; results trail the input by image_width + 1 pixels, and image_width + 1
// drain words after the last pixel flush the tail. Pipeline: position/counter
// update and line store read in the accept cycle, window update and result in
// the next, then a 3-word output queue, so a stalled sink does not block the
// input until the queue fills. The two line stores share one 2-bit wide RAM
// (one read, one write per clock). After reset the line stores are zeroed in
// a clearing pass with in_ch.ready low (config writes still taken). Each
// config write holds in_ch.ready low while a bit-serial divider rebuilds the
// output column/row from the raster position for the new width.
// ---------------------------------------------------------------------------
module binary_morphology_3x3_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  bmorph_in_if.sink                           in_ch,
  bmorph_out_if.source                        out_ch,
  input  logic                                cfg_wr_en,
  input  bmorph_pkg::cfg_reg_t                cfg_index,
  input  logic [bmorph_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
  import bmorph_pkg::*;

  // configuration
  logic [WIDTH_W-1:0]  image_width_r;
  logic [HEIGHT_W-1:0] image_height_r;
  logic                operation_r;
  logic [2:0]          element_shape_r;
  logic [WIDTH_W-1:0]  w_use;
  logic [HEIGHT_W-1:0] h_use;
  logic [POS_W-1:0]    area_m1_r;
  logic [WIDTH_W+HEIGHT_W-1:0] area_full;

  // input position
  logic [COL_W-1:0] in_column_r, in_column_nxt;
  logic [1:0]       in_row_r, in_row_nxt;      // saturates at 2
  logic [POS_W-1:0] out_pos_r;
  logic [COL_W-1:0] ox_r;
  logic [POS_W-1:0] oy_r;

  // line store clear and divider
  logic             clr_active_r;
  logic [COL_W-1:0] clr_addr_r;
  logic             div_busy_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [COL_W-1:0] div_rem_r, div_rem_nxt;
  logic [POS_W-1:0] div_dq_r;
  logic [COL_W:0]   div_sh;
  logic             div_ge;

  // accept stage
  logic             in_ready;
  logic             accept, discard, a_take;
  logic             wrap_pre;
  logic [COL_W-1:0] a_c;
  logic [1:0]       a_row1;
  logic             a_emit, a_last;
  logic [COL_W:0]   a_col_inc;
  logic [2:0]       a_xin, a_yin;
  logic [POS_W:0]   oy_ext;
  logic [POS_W:0]   h_ext;
  logic [COL_W:0]   ox_ext;

  // window stage
  logic             b_vld_r;
  logic             b_pix_r;
  logic [COL_W-1:0] b_col_r;
  logic             b_emit_r, b_last_r;
  logic [2:0]       b_xin_r, b_yin_r;
  logic             fwd_r;
  logic [1:0]       fwd_data_r;
  logic [1:0]       ram_q, store_q;
  logic [1:0]       b_wr_data;
  logic [8:0]       window_r, window_nxt;
  logic [8:0]       mask;
  logic             centre, b_result, dil_any;

  // ram port
  logic             ram_we;
  logic [COL_W-1:0] ram_waddr;
  logic [1:0]       ram_wdata;

  // output queue
  result_t               fifo_mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] fifo_wr_r, fifo_rd_r;
  logic [FIFO_PTR_W-1:0] fifo_cnt_r;
  logic                  push, pop;
  logic [FIFO_PTR_W:0]   occupancy;

  function automatic logic [1:0] row_inc(input logic [1:0] r);
    return (r == 2'd0) ? 2'd1 : 2'd2;
  endfunction

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // ---------------------------------------------------------------- config
  always_comb begin
    w_use = image_width_r;
    if (image_width_r < WIDTH_W'(3)) w_use = WIDTH_W'(3);
    if (image_width_r > WIDTH_W'(MAX_WIDTH)) w_use = WIDTH_W'(MAX_WIDTH);
    h_use = image_height_r;
    if (image_height_r < HEIGHT_W'(3)) h_use = HEIGHT_W'(3);
    if (image_height_r > HEIGHT_W'(MAX_HEIGHT)) h_use = HEIGHT_W'(MAX_HEIGHT);
  end

  assign area_full = w_use * h_use;

  always_ff @(posedge clk) begin
    area_m1_r <= POS_W'(area_full - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= WIDTH_RESET;
      image_height_r  <= HEIGHT_RESET;
      operation_r     <= OP_ERODE;
      element_shape_r <= SHAPE_CROSS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   image_width_r   <= cfg_wr_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:  image_height_r  <= cfg_wr_data[HEIGHT_W-1:0];
        REG_OPERATION:     operation_r     <= cfg_wr_data[0];
        REG_ELEMENT_SHAPE: element_shape_r <= cfg_wr_data[2:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == COL_W'(MAX_WIDTH - 1)) clr_active_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- divider
  // out_pos / w_use, one quotient bit per cycle
  assign div_sh      = {div_rem_r, div_dq_r[POS_W-1]};
  assign div_ge      = div_sh >= w_use;
  assign div_rem_nxt = div_ge ? COL_W'(div_sh - w_use) : div_sh[COL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else if (cfg_wr_en) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= DIV_CNT_W'(POS_W);
    end else if (div_busy_r) begin
      if (div_cnt_r == '0) div_busy_r <= 1'b0;
      else div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_wr_en) begin
      div_rem_r <= '0;
      div_dq_r  <= out_pos_r;
    end else if (div_busy_r && div_cnt_r != '0) begin
      div_rem_r <= div_rem_nxt;
      div_dq_r  <= {div_dq_r[POS_W-2:0], div_ge};
    end
  end

  // ---------------------------------------------------------------- accept
  assign occupancy = {1'b0, fifo_cnt_r} + (FIFO_PTR_W + 1)'(b_vld_r & b_emit_r);
  assign in_ready  = !clr_active_r && !div_busy_r && (occupancy <= (FIFO_PTR_W + 1)'(2));
  assign in_ch.ready = in_ready;

  assign accept  = in_ch.valid && in_ready;
  assign discard = in_ch.kind && (in_row_r == 2'd0) && (in_column_r == '0);
  assign a_take  = accept && !discard;

  always_comb begin
    wrap_pre  = {1'b0, in_column_r} >= w_use;
    a_c       = wrap_pre ? '0 : in_column_r;
    a_row1    = wrap_pre ? row_inc(in_row_r) : in_row_r;
    a_emit    = (a_row1 == 2'd2) || ((a_row1 == 2'd1) && (a_c != '0));
    a_col_inc = {1'b0, a_c} + 1'b1;
    if (a_col_inc >= w_use) begin
      in_column_nxt = '0;
      in_row_nxt    = row_inc(a_row1);
    end else begin
      in_column_nxt = a_col_inc[COL_W-1:0];
      in_row_nxt    = a_row1;
    end
    a_last = out_pos_r >= area_m1_r;
  end

  // interior tests for the output pixel and its left/right, up/down neighbors
  always_comb begin
    ox_ext   = {1'b0, ox_r};
    oy_ext   = {1'b0, oy_r};
    h_ext    = (POS_W + 1)'(h_use);
    a_xin[0] = ox_r >= COL_W'(2);
    a_xin[1] = (ox_r != '0) && (ox_ext + 2'd2 <= w_use);
    a_xin[2] = ox_ext + 2'd3 <= w_use;
    a_yin[0] = (oy_r >= POS_W'(2)) && (oy_ext + 1'b1 <= h_ext);
    a_yin[1] = (oy_r != '0) && (oy_ext + 2'd2 <= h_ext);
    a_yin[2] = oy_ext + 2'd3 <= h_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_column_r <= '0;
      in_row_r    <= '0;
      out_pos_r   <= '0;
      ox_r        <= '0;
      oy_r        <= '0;
    end else if (div_busy_r) begin
      if (div_cnt_r == '0) begin
        ox_r <= div_rem_r;
        oy_r <= div_dq_r;
      end
    end else if (a_take) begin
      if (a_emit && a_last) begin
        in_column_r <= '0;
        in_row_r    <= '0;
        out_pos_r   <= '0;
        ox_r        <= '0;
        oy_r        <= '0;
      end else begin
        in_column_r <= in_column_nxt;
        in_row_r    <= in_row_nxt;
        if (a_emit) begin
          out_pos_r <= out_pos_r + 1'b1;
          if ({1'b0, ox_r} + 1'b1 >= w_use) begin
            ox_r <= '0;
            oy_r <= oy_r + 1'b1;
          end else begin
            ox_r <= ox_r + 1'b1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_take;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      b_pix_r    <= !in_ch.kind && in_ch.pixel_on;
      b_col_r    <= a_c;
      b_emit_r   <= a_emit;
      b_last_r   <= a_last;
      b_xin_r    <= a_xin;
      b_yin_r    <= a_yin;
      // the RAM returns the old entry if the stage ahead writes it now
      fwd_r      <= b_vld_r && (b_col_r == a_c);
      fwd_data_r <= b_wr_data;
    end
  end

  assign store_q   = fwd_r ? fwd_data_r : ram_q;     // {top, mid}
  assign b_wr_data = {store_q[0], b_pix_r};          // top <= mid, mid <= pixel
  assign window_nxt = {b_pix_r, window_r[8:7], store_q[0], window_r[5:4],
                       store_q[1], window_r[2:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (b_vld_r) begin
      window_r <= window_nxt;
    end
  end

  always_comb begin
    mask    = shape_mask(element_shape_r);
    centre  = window_nxt[4];
    dil_any = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        dil_any = dil_any | (mask[r*3+c] & window_nxt[r*3+c] & b_yin_r[r] & b_xin_r[c]);
      end
    end
    if (operation_r == OP_DILATE) begin
      b_result = centre | dil_any;
    end else if (b_xin_r[1] && b_yin_r[1]) begin
      b_result = centre && ((window_nxt & mask) == mask);
    end else begin
      b_result = centre;
    end
  end

  assign ram_we    = clr_active_r || b_vld_r;
  assign ram_waddr = clr_active_r ? clr_addr_r : b_col_r;
  assign ram_wdata = clr_active_r ? 2'b00 : b_wr_data;

  bmorph_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (a_take),
    .rd_addr (a_c),
    .rd_data (ram_q)
  );

  // ---------------------------------------------------------------- output queue
  assign push = b_vld_r && b_emit_r;
  assign pop  = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_wr_r  <= '0;
      fifo_rd_r  <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) fifo_wr_r <= ptr_inc(fifo_wr_r);
      if (pop)  fifo_rd_r <= ptr_inc(fifo_rd_r);
      if (push && !pop)      fifo_cnt_r <= fifo_cnt_r + 1'b1;
      else if (pop && !push) fifo_cnt_r <= fifo_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem_r[fifo_wr_r] <= '{result_on: b_result, frame_last: b_last_r};
    end
  end

  assign out_ch.valid      = fifo_cnt_r != '0;
  assign out_ch.result_on  = fifo_mem_r[fifo_rd_r].result_on;
  assign out_ch.frame_last = fifo_mem_r[fifo_rd_r].frame_last;

  // ---------------------------------------------------------------- checks
  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (fifo_cnt_r != FIFO_PTR_W'(FIFO_DEPTH)))
    else $error("output queue overflow");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (a_take && a_emit && a_last) |=> (in_column_r == '0 && in_row_r == 2'd0 &&
                                      out_pos_r == '0))
    else $error("frame end did not restart the input position");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !div_busy_r |-> ({1'b0, ox_r} < w_use))
    else $error("output column outside image width");

endmodule

[rtl/bmorph_ram.sv]
// ---------------------------------------------------------------------------
// bmorph_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module bmorph_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
